[design/sbm_pkg.sv]
`timescale 1ns / 1ps
// Package of the stereo block matcher: controller states, the command and
// status structs between controller and datapath, and fixed field widths.
// No dependencies.
package sbm_pkg;

	localparam int COORD_W = 8;
	localparam int PIX_W   = 8;
	localparam int DISP_W  = 6;
	localparam int COST_W  = 23;
	localparam int DIM_W   = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COST_MODE    = 2'd2;

	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	localparam logic MODE_SSD = 1'b0;
	localparam logic MODE_SAD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SWEEP,
		ST_DRAIN,
		ST_FINISH
	} sbm_state_t;

	typedef struct packed {
		logic start;
		logic load_we;
		logic issue;
		logic out_load;
	} sbm_cmd_t;

	typedef struct packed {
		logic coord_err;
		logic last_issue;
		logic result_done;
	} sbm_stat_t;

endpackage

[design/sbm_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the stereo block matcher: sequences loads, query sweeps and
// the result register handshake. Depends on sbm_pkg.
module sbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              func,
	output logic              m_tvalid,
	input  logic              m_tready,
	output sbm_pkg::sbm_cmd_t cmd,
	input  sbm_pkg::sbm_stat_t stat
);
	import sbm_pkg::*;

	sbm_state_t state_q;
	sbm_state_t state_nxt;
	logic       m_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		cmd          = '0;
		s_tready     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (func == FUNC_QUERY) begin
						cmd.start = 1'b1;
						state_nxt = ST_CHECK;
					end else begin
						cmd.load_we = 1'b1;
					end
				end
			end
			ST_CHECK: begin
				state_nxt = stat.coord_err ? ST_FINISH : ST_SWEEP;
			end
			ST_SWEEP: begin
				cmd.issue = 1'b1;
				if (stat.last_issue) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (stat.result_done) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// The result register must be empty or emptying this cycle.
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = m_valid_q;

endmodule

[design/sbm_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the stereo block matcher: configuration registers, the two
// frame memories, the window and shift counters, the shared difference and
// accumulate pipeline, and the result register. Depends on sbm_pkg.
module sbm_datapath #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int WINDOW     = 9,
	parameter int SHIFTS     = 63
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [sbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbm_pkg::DIM_W-1:0]       cfg_data,
	input  logic [sbm_pkg::COORD_W-1:0]     pos_x,
	input  logic [sbm_pkg::COORD_W-1:0]     pos_y,
	input  logic [sbm_pkg::PIX_W-1:0]       left_pixel,
	input  logic [sbm_pkg::PIX_W-1:0]       right_pixel,
	input  sbm_pkg::sbm_cmd_t               cmd,
	output sbm_pkg::sbm_stat_t              stat,
	output logic [sbm_pkg::DISP_W-1:0]      disparity,
	output logic [sbm_pkg::COST_W-1:0]      best_cost,
	output logic                            coord_error
);
	import sbm_pkg::*;

	localparam int HALF   = WINDOW / 2;
	localparam int SIDE   = 2 * HALF + 1;
	localparam int CNT_W  = $clog2(SIDE + 1);
	localparam int D_W    = $clog2(SHIFTS + 1);
	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CRD_W  = $clog2(MAX_WIDTH + MAX_HEIGHT + WINDOW + SHIFTS + 1024) + 1;
	localparam int TERM_W = 2 * PIX_W;
	localparam int ACC_W  = $clog2(SIDE * SIDE * 65025 + 1);

	// Configuration registers.
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic             mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
			mode_q   <= MODE_SSD;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				CFG_COST_MODE:    mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic signed [CRD_W-1:0] eff_w;
	logic signed [CRD_W-1:0] eff_h;

	assign eff_w = (32'(width_q) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : CRD_W'(width_q);
	assign eff_h = (32'(height_q) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : CRD_W'(height_q);

	// Frame memories.
	logic [PIX_W-1:0]  left_mem  [DEPTH];
	logic [PIX_W-1:0]  right_mem [DEPTH];
	logic [ADDR_W-1:0] waddr;
	logic              wr_in_range;

	assign wr_in_range = (32'(pos_x) < MAX_WIDTH) && (32'(pos_y) < MAX_HEIGHT);
	assign waddr       = ADDR_W'(32'(pos_y) * MAX_WIDTH + 32'(pos_x));

	// Query position, error flag and sweep counters.
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic               err_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic [D_W-1:0]     d_q;
	logic               i_last;
	logic               j_last;
	logic               d_last;

	assign i_last = (i_q == CNT_W'(SIDE - 1));
	assign j_last = (j_q == CNT_W'(SIDE - 1));
	assign d_last = (d_q == D_W'(SHIFTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			d_q <= '0;
		end else if (cmd.start) begin
			i_q <= '0;
			j_q <= '0;
			d_q <= '0;
		end else if (cmd.issue) begin
			if (i_last) begin
				i_q <= '0;
				if (j_last) begin
					j_q <= '0;
					d_q <= d_last ? '0 : d_q + D_W'(1);
				end else begin
					j_q <= j_q + CNT_W'(1);
				end
			end else begin
				i_q <= i_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= pos_x;
			y_q   <= pos_y;
			err_q <= (CRD_W'(pos_x) >= eff_w) || (CRD_W'(pos_y) >= eff_h);
		end
		if (cmd.load_we && wr_in_range) begin
			left_mem[waddr]  <= left_pixel;
			right_mem[waddr] <= right_pixel;
		end
	end

	// Window coordinates of the term being issued.
	logic signed [CRD_W-1:0] col;
	logic signed [CRD_W-1:0] row;
	logic signed [CRD_W-1:0] rcol;
	logic                    in_image;
	logic                    rval;
	logic [ADDR_W-1:0]       laddr;
	logic [ADDR_W-1:0]       raddr;

	assign col  = CRD_W'(x_q) + CRD_W'(i_q) - CRD_W'(HALF);
	assign row  = CRD_W'(y_q) + CRD_W'(j_q) - CRD_W'(HALF);
	assign rcol = col - CRD_W'(d_q);

	assign in_image = !col[CRD_W-1] && !row[CRD_W-1] && (col < eff_w) && (row < eff_h);
	assign rval     = in_image && !rcol[CRD_W-1];
	assign laddr    = in_image ? ADDR_W'(32'(row) * MAX_WIDTH + 32'(col)) : '0;
	assign raddr    = rval ? ADDR_W'(32'(row) * MAX_WIDTH + 32'(rcol)) : '0;

	// Pipeline: s1 addresses, s2 read data, s3 difference, s4 term, s5 shift sum.
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic              first_s1, first_s2, first_s3, first_s4;
	logic              last_s1, last_s2, last_s3, last_s4;
	logic              qlast_s1, qlast_s2, qlast_s3, qlast_s4, qlast_s5;
	logic [D_W-1:0]    d_s1, d_s2, d_s3, d_s4, d_s5;
	logic              lval_s1, rval_s1, lval_s2, rval_s2;
	logic [ADDR_W-1:0] laddr_s1, raddr_s1;
	logic [PIX_W-1:0]  lpix_s2, rpix_s2;
	logic [PIX_W-1:0]  diff_s3;
	logic [TERM_W-1:0] term_s4;
	logic [ACC_W-1:0]  sum_s5;
	logic [ACC_W-1:0]  acc_q;
	logic [ACC_W-1:0]  acc_sum;
	logic [PIX_W-1:0]  lop;
	logic [PIX_W-1:0]  rop;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= cmd.issue;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4 && last_s4;
			done_q <= v_s5 && qlast_s5;
		end
	end

	assign lop     = lval_s2 ? lpix_s2 : '0;
	assign rop     = rval_s2 ? rpix_s2 : '0;
	assign acc_sum = first_s4 ? ACC_W'(term_s4) : acc_q + ACC_W'(term_s4);

	always_ff @(posedge clk) begin
		first_s1 <= (i_q == '0) && (j_q == '0);
		last_s1  <= i_last && j_last;
		qlast_s1 <= i_last && j_last && d_last;
		d_s1     <= d_q;
		lval_s1  <= in_image;
		rval_s1  <= rval;
		laddr_s1 <= laddr;
		raddr_s1 <= raddr;

		first_s2 <= first_s1;
		last_s2  <= last_s1;
		qlast_s2 <= qlast_s1;
		d_s2     <= d_s1;
		lval_s2  <= lval_s1;
		rval_s2  <= rval_s1;
		lpix_s2  <= left_mem[laddr_s1];
		rpix_s2  <= right_mem[raddr_s1];

		first_s3 <= first_s2;
		last_s3  <= last_s2;
		qlast_s3 <= qlast_s2;
		d_s3     <= d_s2;
		diff_s3  <= (lop > rop) ? lop - rop : rop - lop;

		first_s4 <= first_s3;
		last_s4  <= last_s3;
		qlast_s4 <= qlast_s3;
		d_s4     <= d_s3;
		term_s4  <= (mode_q == MODE_SAD) ? TERM_W'(diff_s3) : diff_s3 * diff_s3;

		if (v_s4) begin
			acc_q <= acc_sum;
		end
		sum_s5   <= acc_sum;
		d_s5     <= d_s4;
		qlast_s5 <= qlast_s4;
	end

	// Running minimum over the shifts; the first shift always loads it, and a
	// strict compare keeps the smaller shift on a tie.
	logic [ACC_W-1:0] best_q;
	logic [D_W-1:0]   best_d_q;

	always_ff @(posedge clk) begin
		if (v_s5 && ((d_s5 == '0) || (sum_s5 < best_q))) begin
			best_q   <= sum_s5;
			best_d_q <= d_s5;
		end
		if (cmd.out_load) begin
			coord_error <= err_q;
			disparity   <= err_q ? '0 : DISP_W'(best_d_q);
			if (err_q) begin
				best_cost <= '0;
			end else if (32'(best_q) > 32'(COST_MAX)) begin
				best_cost <= COST_MAX;
			end else begin
				best_cost <= COST_W'(best_q);
			end
		end
	end

	assign stat.coord_err   = err_q;
	assign stat.last_issue  = i_last && j_last && d_last;
	assign stat.result_done = done_q;

endmodule

[design/stereo_block_match_disparity.sv]
`timescale 1ns / 1ps
// Stereo block matcher, top level: wires the controller and the datapath.
// Depends on sbm_pkg, sbm_ctrl and sbm_datapath.
//
// A load transaction (tuser low) writes one left and one right pixel and is
// taken whenever the block is idle, so frames load at one pixel per clock. A
// query transaction (tuser high) reads one left and one right pixel per cycle
// from the frame memories through a single difference and accumulate unit,
// for every window position at each of the SHIFTS shifts; a query outside
// the configured image skips the sweep and finishes with the error flag set.
// No new input is taken while a query runs, but a finished result waits in
// its own register while loads continue. Configuration writes are always
// taken and must only be made while the block is idle. The frame memories
// are not cleared: load every pixel a query window can touch before
// querying.
module stereo_block_match_disparity #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256,
	parameter int WINDOW     = 9,
	parameter int SHIFTS     = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // pos_x[7:0], pos_y[15:8], left_pixel[23:16], right_pixel[31:24]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // disparity[5:0], best_cost[28:6], zero[31:29]
	output logic        m_tuser,   // coord_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import sbm_pkg::*;

	sbm_cmd_t            cmd;
	sbm_stat_t           stat;
	logic [DISP_W-1:0]   disparity;
	logic [COST_W-1:0]   best_cost;

	assign cfg_ready = 1'b1;

	sbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	sbm_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.WINDOW     (WINDOW),
		.SHIFTS     (SHIFTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.pos_x       (s_tdata[7:0]),
		.pos_y       (s_tdata[15:8]),
		.left_pixel  (s_tdata[23:16]),
		.right_pixel (s_tdata[31:24]),
		.cmd         (cmd),
		.stat        (stat),
		.disparity   (disparity),
		.best_cost   (best_cost),
		.coord_error (m_tuser)
	);

	assign m_tdata = {3'b000, best_cost, disparity};

endmodule

[design/sbm_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the stereo block matcher, bound to the top level.
// Depends on stereo_block_match_disparity.
module sbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// A query keeps the block busy on the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input taken straight after a query transaction");

	// Loads never stall the input side.
	a_load_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser |=> s_tready)
		else $error("block stalled after a load transaction");

	// An out-of-image query reports zero shift and zero cost.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 32'd0))
		else $error("error result carries non-zero data");

endmodule

bind stereo_block_match_disparity sbm_checker u_sbm_checker (.*);

[verif/tb_stereo_block_match_disparity.sv]
`timescale 1ns / 1ps
// Testbench for stereo_block_match_disparity: loads left/right frames, runs disparity
// queries over streaming handshakes and checks each result against a behavioural block
// matcher held here or a fixed expected result. Depends on sbm_pkg and the RTL only.
module tb_stereo_block_match_disparity;
	import sbm_pkg::*;

	localparam int MAX_W        = 256;
	localparam int MAX_H        = 256;
	localparam int WIN          = 9;
	localparam int SHIFT_COUNT  = 63;
	localparam int WIN_HALF     = WIN / 2;
	localparam int TRUE_SHIFT   = 20;
	localparam int SCENE_W      = MAX_W + TRUE_SHIFT + 4;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES  = 12000;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT  = 40000;

	typedef struct packed {
		logic              func;
		bit [COORD_W-1:0]  px;
		bit [COORD_W-1:0]  py;
		bit [PIX_W-1:0]    lp;
		bit [PIX_W-1:0]    rp;
	} pixel_op_t;

	typedef struct packed {
		bit [DISP_W-1:0] disparity;
		bit [COST_W-1:0] best_cost;
		bit              coord_error;
	} match_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		bit [DIM_W-1:0]       reg_val;
		pixel_op_t            op;
		bit                   typed;
		match_t               want;
	} plan_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata = '0;   // pos_x, pos_y, left_pixel, right_pixel
	logic                 s_tuser = 1'b0; // func
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;        // disparity, best_cost, zero fill
	logic                 m_tuser;        // coord_error
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;

	// Mirror of the block: frame stores and configuration.
	bit [PIX_W-1:0] left_px [0:MAX_W*MAX_H-1];
	bit [PIX_W-1:0] right_px [0:MAX_W*MAX_H-1];
	bit [DIM_W-1:0] img_w = 9'd256;
	bit [DIM_W-1:0] img_h = 9'd256;
	logic           cost_sad = MODE_SSD;

	match_t    pending_matches [$];
	plan_row_t plan [$];
	int        mismatches = 0;
	bit        calm = 1'b0;
	logic      hold_arm = 1'b0;
	bit        hold_taken = 1'b0;
	int        hold_left = 0;
	int        stall_cycles;

	stereo_block_match_disparity #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H),
		.WINDOW    (WIN),
		.SHIFTS    (SHIFT_COUNT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned frame_px(input bit left_side, input int col, input int row,
			input int w, input int h);
		if (col < 0 || row < 0 || col >= w || row >= h) begin
			return 0;
		end
		return left_side ? left_px[row*MAX_W + col] : right_px[row*MAX_W + col];
	endfunction

	function automatic match_t predict_match(input bit [COORD_W-1:0] qx,
			input bit [COORD_W-1:0] qy);
		int          w, h, d, i, j, col, row;
		int unsigned lv, rv, diff, acc, best;
		match_t      res;
		w = (img_w > MAX_W) ? MAX_W : int'(img_w);
		h = (img_h > MAX_H) ? MAX_H : int'(img_h);
		res = '0;
		if (int'(qx) >= w || int'(qy) >= h) begin
			res.coord_error = 1'b1;
			return res;
		end
		best = 32'hFFFF_FFFF;
		for (d = 0; d < SHIFT_COUNT; d++) begin
			acc = 0;
			for (j = -WIN_HALF; j <= WIN_HALF; j++) begin
				row = int'(qy) + j;
				for (i = -WIN_HALF; i <= WIN_HALF; i++) begin
					col = int'(qx) + i;
					lv = frame_px(1'b1, col, row, w, h);
					// The right pixel is blanked when the unshifted column leaves the image.
					rv = (col >= 0 && col < w) ? frame_px(1'b0, col - d, row, w, h) : 0;
					diff = (lv > rv) ? lv - rv : rv - lv;
					acc += (cost_sad == MODE_SAD) ? diff : diff * diff;
				end
			end
			// Strictly smaller only, so a tie keeps the smaller shift.
			if (acc < best) begin
				best = acc;
				res.disparity = DISP_W'(d);
			end
		end
		if (best > COST_MAX) begin
			best = COST_MAX;
		end
		res.best_cost = COST_W'(best);
		return res;
	endfunction

	function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input bit [DIM_W-1:0] val);
		plan_row_t row;
		row = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, op: '0, typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t op_row(input logic func, input bit [7:0] x, input bit [7:0] y,
			input bit [7:0] l, input bit [7:0] r);
		plan_row_t row;
		row = '{kind: ROW_ITEM, reg_idx: '0, reg_val: '0, op: {func, x, y, l, r},
			typed: 1'b0, want: '0};
		return row;
	endfunction

	function automatic plan_row_t typed_row(input bit [7:0] x, input bit [7:0] y,
			input bit [DISP_W-1:0] disp, input bit [COST_W-1:0] cost, input bit err);
		plan_row_t row;
		row = op_row(FUNC_QUERY, x, y, 8'd0, 8'd0);
		row.typed = 1'b1;
		row.want = {disp, cost, err};
		return row;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// Offers one transaction and, once it is taken, updates the mirror or files
	// the expected match. A gap before the offer lowers tvalid in a step of its own.
	task automatic send_op(input pixel_op_t op, input bit typed, input match_t want);
		if (!calm) begin
			while ($urandom_range(99) < 10) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= op.func;
		s_tdata <= {op.rp, op.lp, op.py, op.px};
		do @(posedge clk); while (!s_tready);
		if (op.func == FUNC_LOAD) begin
			left_px[int'(op.py)*MAX_W + int'(op.px)] = op.lp;
			right_px[int'(op.py)*MAX_W + int'(op.px)] = op.rp;
		end else begin
			pending_matches.push_back(typed ? want : predict_match(op.px, op.py));
		end
	endtask

	// Stops offering and waits until every expected match has come back.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_matches.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [DIM_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_IMAGE_WIDTH: begin
				img_w = val;
			end
			CFG_IMAGE_HEIGHT: begin
				img_h = val;
			end
			CFG_COST_MODE: begin
				cost_sad = val[0];
			end
			default: begin
			end
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// One setting: configure, load the image from first_row down as a shifted
	// textured scene, then a random mix of loads and queries. In-image queries
	// stay far enough below first_row that their windows only touch loaded rows.
	task automatic run_phase(input bit [DIM_W-1:0] w_val, input bit [DIM_W-1:0] h_val,
			input logic mode, input bit quiet, input int first_row, input int mix_items);
		int        w, h, shift, c, r, k, lo;
		bit [7:0]  line [0:SCENE_W-1];
		pixel_op_t op;
		settle();
		write_reg(CFG_IMAGE_WIDTH, w_val);
		write_reg(CFG_IMAGE_HEIGHT, h_val);
		// Only bit 0 selects the cost; the upper bits are don't-care.
		write_reg(CFG_COST_MODE, {8'($urandom_range(255)), mode});
		calm = quiet;
		w = (w_val > MAX_W) ? MAX_W : int'(w_val);
		h = (h_val > MAX_H) ? MAX_H : int'(h_val);
		lo = (first_row == 0) ? 0 : first_row + WIN_HALF;
		shift = $urandom_range(TRUE_SHIFT);
		for (r = first_row; r < h; r++) begin
			foreach (line[c]) begin
				line[c] = 8'($urandom_range(255));
			end
			for (c = 0; c < w; c++) begin
				op.func = FUNC_LOAD;
				op.px = 8'(c);
				op.py = 8'(r);
				op.lp = line[c];
				op.rp = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : line[c + shift];
				send_op(op, 1'b0, '0);
			end
		end
		for (k = 0; k < mix_items; k++) begin
			op.lp = 8'($urandom_range(255));
			op.rp = 8'($urandom_range(255));
			if ($urandom_range(1) == 1) begin
				op.func = FUNC_QUERY;
				if (w > 0 && h > 0 && (($urandom_range(4) != 0) || (w == MAX_W && h == MAX_H)))
						begin
					op.px = 8'($urandom_range(w - 1));
					op.py = 8'($urandom_range(h - 1, lo));
				end else if (w < MAX_W) begin
					op.px = 8'($urandom_range(MAX_W - 1, w));
					op.py = 8'($urandom_range(255));
				end else begin
					op.px = 8'($urandom_range(255));
					op.py = 8'($urandom_range(MAX_H - 1, h));
				end
			end else begin
				op.func = FUNC_LOAD;
				if (w > 0 && h > 0 && $urandom_range(1) == 1) begin
					op.px = 8'($urandom_range(w - 1));
					op.py = 8'($urandom_range(h - 1));
				end else begin
					op.px = 8'($urandom_range(255));
					op.py = 8'($urandom_range(255));
				end
			end
			send_op(op, 1'b0, '0);
		end
	endtask

	// Result side: checks every transaction and drives tready, including the
	// one long hold-off that backs the block up into its input.
	always @(posedge clk) begin
		match_t want;
		if (m_tvalid && m_tready) begin
			if (pending_matches.size() == 0) begin
				report_mismatch("unexpected result, disparity", m_tdata[DISP_W-1:0], 0);
			end else begin
				want = pending_matches.pop_front();
				if (m_tdata[DISP_W-1:0] != want.disparity) begin
					report_mismatch("disparity", m_tdata[DISP_W-1:0], want.disparity);
				end
				if (m_tdata[DISP_W+COST_W-1:DISP_W] != want.best_cost) begin
					report_mismatch("best_cost", m_tdata[DISP_W+COST_W-1:DISP_W], want.best_cost);
				end
				if (m_tuser != want.coord_error) begin
					report_mismatch("coord_error", m_tuser, want.coord_error);
				end
			end
		end
		if (hold_arm && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || ($urandom_range(99) >= 10);
		end
	end

	initial begin
		stall_cycles = 0;
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
			end
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		hold_arm <= 1'b1;

		// A 3x2 image with bright left and black right pixels costs the same at
		// every shift, so the zero shift wins the tie.
		plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 9'd3));
		plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 9'd2));
		plan.push_back(cfg_row(CFG_COST_MODE, {8'd0, MODE_SSD}));
		plan.push_back(op_row(FUNC_LOAD, 8'd0, 8'd0, 8'd255, 8'd0));
		plan.push_back(op_row(FUNC_LOAD, 8'd1, 8'd0, 8'd255, 8'd0));
		plan.push_back(op_row(FUNC_LOAD, 8'd2, 8'd0, 8'd255, 8'd0));
		plan.push_back(op_row(FUNC_LOAD, 8'd0, 8'd1, 8'd255, 8'd0));
		plan.push_back(op_row(FUNC_LOAD, 8'd1, 8'd1, 8'd255, 8'd0));
		plan.push_back(op_row(FUNC_LOAD, 8'd2, 8'd1, 8'd255, 8'd0));
		plan.push_back(typed_row(8'd1, 8'd0, 6'd0, 23'd390150, 1'b0));
		plan.push_back(typed_row(8'd255, 8'd255, 6'd0, 23'd0, 1'b1));
		plan.push_back(typed_row(8'd3, 8'd0, 6'd0, 23'd0, 1'b1));
		plan.push_back(typed_row(8'd0, 8'd2, 6'd0, 23'd0, 1'b1));
		// Outside the configured size but inside the store: written, never read here.
		plan.push_back(op_row(FUNC_LOAD, 8'd255, 8'd255, 8'd0, 8'd255));
		plan.push_back(cfg_row(CFG_COST_MODE, {8'd0, MODE_SAD}));
		plan.push_back(typed_row(8'd2, 8'd1, 6'd0, 23'd1530, 1'b0));
		plan.push_back(op_row(FUNC_LOAD, 8'd0, 8'd0, 8'd0, 8'd255));
		plan.push_back(op_row(FUNC_LOAD, 8'd1, 8'd1, 8'd7, 8'd200));
		plan.push_back(op_row(FUNC_QUERY, 8'd0, 8'd0, 8'd0, 8'd0));
		plan.push_back(op_row(FUNC_QUERY, 8'd2, 8'd1, 8'd0, 8'd0));
		plan.push_back(cfg_row(CFG_COST_MODE, {8'd0, MODE_SSD}));
		plan.push_back(op_row(FUNC_QUERY, 8'd1, 8'd1, 8'd0, 8'd0));
		// A zero size turns every query into an error.
		plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 9'd0));
		plan.push_back(typed_row(8'd0, 8'd0, 6'd0, 23'd0, 1'b1));
		plan.push_back(cfg_row(CFG_IMAGE_WIDTH, 9'd3));
		plan.push_back(cfg_row(CFG_IMAGE_HEIGHT, 9'd0));
		plan.push_back(typed_row(8'd1, 8'd1, 6'd0, 23'd0, 1'b1));

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG) begin
				settle();
				write_reg(plan[k].reg_idx, plan[k].reg_val);
			end else begin
				send_op(plan[k].op, plan[k].typed, plan[k].want);
			end
		end

		// A small image without idling, a one-pixel column whose oversize height
		// is clamped (only its bottom rows are loaded), the two all-error sizes,
		// then small random images.
		run_phase(9'd6, 9'd4, MODE_SSD, 1'b1, 0, 8);
		run_phase(9'd1, 9'd511, MODE_SAD, 1'b0, 248, 6);
		run_phase(9'd0, 9'd300, MODE_SSD, 1'b0, 0, 3);
		run_phase(9'd9, 9'd0, MODE_SAD, 1'b0, 0, 3);
		repeat (2) begin
			run_phase(9'($urandom_range(8, 1)), 9'($urandom_range(4, 1)),
				1'($urandom_range(1)), 1'b0, 0, 8);
		end

		settle();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[stereo_block_match_disparity.f]
design/sbm_pkg.sv
design/sbm_ctrl.sv
design/sbm_datapath.sv
design/stereo_block_match_disparity.sv
design/sbm_checker.sv
verif/tb_stereo_block_match_disparity.sv
